// File: rtl/core/wpmp_pkg.sv
package wpmp_pkg;

    // Field widths of the byte stream and of the result stream.
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 4;
    localparam int RATE_W   = 32;
    localparam int PHASE_W  = 3;

    // Expected sample rate after reset.
    localparam logic [RATE_W-1:0] DEFAULT_RATE = 32'd16000;

    // Parser phases.
    localparam logic [PHASE_W-1:0] PH_RIFF  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CHDR  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FMT   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAD   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DATA  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DRAIN = 3'd6;

    // Four-character tags, first character in the top byte.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE       = 4'd0;
    localparam logic [ERR_W-1:0] ERR_SHORT_HDR  = 4'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_WAVE   = 4'd2;
    localparam logic [ERR_W-1:0] ERR_FMT_SMALL  = 4'd3;
    localparam logic [ERR_W-1:0] ERR_FMT_TRUNC  = 4'd4;
    localparam logic [ERR_W-1:0] ERR_DATA_TRUNC = 4'd5;
    localparam logic [ERR_W-1:0] ERR_NO_FMT     = 4'd6;
    localparam logic [ERR_W-1:0] ERR_NO_DATA    = 4'd7;
    localparam logic [ERR_W-1:0] ERR_NOT_PCM    = 4'd8;
    localparam logic [ERR_W-1:0] ERR_NOT_MONO   = 4'd9;
    localparam logic [ERR_W-1:0] ERR_RATE       = 4'd10;
    localparam logic [ERR_W-1:0] ERR_BITS       = 4'd11;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [ERR_W-1:0]           err;
        logic                       last;
    } t_result;

endpackage

// File: rtl/core/wav_pcm16_mono_parser.sv
// Channel   Direction  Handshake                   Payload
// in        to block   i_in_valid / o_in_ready     i_in_byte, i_end_of_file
// out       from block o_out_valid / i_out_ready   o_kind, o_sample, o_error_code, o_last
// cfg       to block   i_cfg_valid / o_cfg_ready   i_cfg_data (expected sample rate)
//
// A byte is parsed from the input register after its transfer, and its
// results (zero, one or two) land in a four-entry result queue; one byte per cycle
// is sustained while the queue drains. The byte that ends a data chunk on a sample
// pushes two results, so the queue output port, at one result per cycle, sets the
// rate then. Input is held off while a byte waits and under two queue slots are free.
// Reset is synchronous, active low, and returns the parser to the RIFF header phase
// with an empty queue and the expected rate at 16000 Hz.
module wav_pcm16_mono_parser
    import wpmp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [BYTE_W-1:0]          i_in_byte,
    input  logic                       i_end_of_file,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [KIND_W-1:0]          o_kind,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic [ERR_W-1:0]           o_error_code,
    output logic                       o_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [RATE_W-1:0]          i_cfg_data
);

    // Configuration register.
    logic [RATE_W-1:0] r_exp_rate;

    // Input register.
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eof;

    // Parser state.
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [31:0]        r_byte_cnt, n_byte_cnt;
    logic [31:0]        r_chunk_len, n_chunk_len;
    logic [31:0]        r_chunk_tag, n_chunk_tag;
    logic               r_hdr_bad, n_hdr_bad;
    logic               r_fmt_seen, n_fmt_seen;
    logic [15:0]        r_fmt_code, n_fmt_code;
    logic [15:0]        r_chan_cnt, n_chan_cnt;
    logic [31:0]        r_decl_rate, n_decl_rate;
    logic [15:0]        r_smp_bits, n_smp_bits;
    logic [7:0]         r_low_byte, n_low_byte;

    // Result queue.
    t_result             r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;

    // Parse step outputs.
    logic              adv;
    logic              pop;
    logic              smp_v;
    logic              sts_v;
    logic [ERR_W-1:0]  sts_err;
    logic [ERR_W-1:0]  fmt_err;
    logic [31:0]       cnt_inc;
    logic [31:0]       shifted_tag;
    t_result           res_smp;
    t_result           res_sts;
    t_result           e0;
    logic [1:0]        n_push;
    logic [QPTR_W-1:0] wp_nx;

    // Handshakes: the parse stage advances when a byte is held and two or more queue slots are free.
    assign adv         = r_in_vld && (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_in_ready  = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && i_out_ready;

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_rate <= DEFAULT_RATE;
        end else if (i_cfg_valid) begin
            r_exp_rate <= i_cfg_data;
        end
    end

    // Input register takes a byte on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_eof  <= i_end_of_file;
        end
    end

    // Format check of the stored fmt fields, in priority order.
    always_comb begin
        if (!r_fmt_seen) begin
            fmt_err = ERR_NO_FMT;
        end else if (r_fmt_code != 16'd1) begin
            fmt_err = ERR_NOT_PCM;
        end else if (r_chan_cnt != 16'd1) begin
            fmt_err = ERR_NOT_MONO;
        end else if (r_decl_rate != r_exp_rate) begin
            fmt_err = ERR_RATE;
        end else if (r_smp_bits != 16'd16) begin
            fmt_err = ERR_BITS;
        end else begin
            fmt_err = ERR_NONE;
        end
    end

    assign cnt_inc     = r_byte_cnt + 32'd1;
    assign shifted_tag = {r_chunk_tag[23:0], r_in_byte};

    // One parse step for the byte in the input register.
    always_comb begin
        n_phase     = r_phase;
        n_byte_cnt  = r_byte_cnt;
        n_chunk_len = r_chunk_len;
        n_chunk_tag = r_chunk_tag;
        n_hdr_bad   = r_hdr_bad;
        n_fmt_seen  = r_fmt_seen;
        n_fmt_code  = r_fmt_code;
        n_chan_cnt  = r_chan_cnt;
        n_decl_rate = r_decl_rate;
        n_smp_bits  = r_smp_bits;
        n_low_byte  = r_low_byte;
        smp_v       = 1'b0;
        sts_v       = 1'b0;
        sts_err     = ERR_NONE;

        case (r_phase)
            PH_RIFF: begin
                n_chunk_tag = shifted_tag;
                n_byte_cnt  = cnt_inc;
                if (r_byte_cnt == 32'd3 && shifted_tag != TAG_RIFF) begin
                    n_hdr_bad = 1'b1;
                end
                if (r_byte_cnt == 32'd11) begin
                    if (r_hdr_bad || shifted_tag != TAG_WAVE) begin
                        n_hdr_bad = 1'b1;
                        sts_v     = 1'b1;
                        sts_err   = ERR_NOT_WAVE;
                    end else if (r_in_eof) begin
                        sts_v   = 1'b1;
                        sts_err = ERR_NO_FMT;
                    end else begin
                        n_phase    = PH_CHDR;
                        n_byte_cnt = '0;
                    end
                end else if (r_in_eof) begin
                    sts_v   = 1'b1;
                    sts_err = ERR_SHORT_HDR;
                end
            end
            PH_CHDR: begin
                // Tag bytes first, then the length, least significant byte first.
                case (r_byte_cnt[2:0])
                    3'd0, 3'd1, 3'd2, 3'd3: n_chunk_tag = shifted_tag;
                    3'd4:    n_chunk_len = {24'd0, r_in_byte};
                    3'd5:    n_chunk_len[15:8] = r_in_byte;
                    3'd6:    n_chunk_len[23:16] = r_in_byte;
                    default: n_chunk_len[31:24] = r_in_byte;
                endcase
                n_byte_cnt = cnt_inc;
                if (r_byte_cnt == 32'd7) begin
                    n_byte_cnt = '0;
                    if (r_chunk_tag == TAG_FMT) begin
                        if (n_chunk_len < 32'd16) begin
                            sts_v   = 1'b1;
                            sts_err = ERR_FMT_SMALL;
                        end else if (r_in_eof) begin
                            sts_v   = 1'b1;
                            sts_err = ERR_FMT_TRUNC;
                        end else begin
                            n_phase = PH_FMT;
                        end
                    end else if (r_chunk_tag == TAG_DATA) begin
                        if (n_chunk_len == 32'd0) begin
                            sts_v   = 1'b1;
                            sts_err = r_fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
                        end else if (r_in_eof) begin
                            sts_v   = 1'b1;
                            sts_err = ERR_DATA_TRUNC;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else if (r_in_eof) begin
                        sts_v   = 1'b1;
                        sts_err = r_fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
                    end else begin
                        n_phase = (n_chunk_len == 32'd0) ? PH_CHDR : PH_SKIP;
                    end
                end else if (r_in_eof) begin
                    sts_v   = 1'b1;
                    sts_err = r_fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
                end
            end
            PH_FMT: begin
                // Pick the format fields out of their byte offsets.
                if (r_byte_cnt == 32'd0) begin
                    n_fmt_code[7:0] = r_in_byte;
                end else if (r_byte_cnt == 32'd1) begin
                    n_fmt_code[15:8] = r_in_byte;
                end else if (r_byte_cnt == 32'd2) begin
                    n_chan_cnt[7:0] = r_in_byte;
                end else if (r_byte_cnt == 32'd3) begin
                    n_chan_cnt[15:8] = r_in_byte;
                end else if (r_byte_cnt[31:2] == 30'd1) begin
                    case (r_byte_cnt[1:0])
                        2'd0:    n_decl_rate[7:0] = r_in_byte;
                        2'd1:    n_decl_rate[15:8] = r_in_byte;
                        2'd2:    n_decl_rate[23:16] = r_in_byte;
                        default: n_decl_rate[31:24] = r_in_byte;
                    endcase
                end else if (r_byte_cnt == 32'd14) begin
                    n_smp_bits[7:0] = r_in_byte;
                end else if (r_byte_cnt == 32'd15) begin
                    n_smp_bits[15:8] = r_in_byte;
                end
                n_byte_cnt = cnt_inc;
                if (cnt_inc == r_chunk_len) begin
                    n_fmt_seen = 1'b1;
                    n_phase    = r_chunk_len[0] ? PH_PAD : PH_CHDR;
                    n_byte_cnt = '0;
                    if (r_in_eof) begin
                        sts_v   = 1'b1;
                        sts_err = ERR_NO_DATA;
                    end
                end else if (r_in_eof) begin
                    sts_v   = 1'b1;
                    sts_err = ERR_FMT_TRUNC;
                end
            end
            PH_SKIP: begin
                n_byte_cnt = cnt_inc;
                if (cnt_inc == r_chunk_len) begin
                    n_phase    = r_chunk_len[0] ? PH_PAD : PH_CHDR;
                    n_byte_cnt = '0;
                end
                if (r_in_eof) begin
                    sts_v   = 1'b1;
                    sts_err = r_fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
                end
            end
            PH_PAD: begin
                n_phase    = PH_CHDR;
                n_byte_cnt = '0;
                if (r_in_eof) begin
                    sts_v   = 1'b1;
                    sts_err = r_fmt_seen ? ERR_NO_DATA : ERR_NO_FMT;
                end
            end
            PH_DATA: begin
                // Even bytes are held; odd bytes complete a little-endian sample.
                if (!r_byte_cnt[0]) begin
                    n_low_byte = r_in_byte;
                end else if (fmt_err == ERR_NONE) begin
                    smp_v = 1'b1;
                end
                n_byte_cnt = cnt_inc;
                if (cnt_inc == r_chunk_len) begin
                    sts_v   = 1'b1;
                    sts_err = fmt_err;
                end else if (r_in_eof) begin
                    sts_v   = 1'b1;
                    sts_err = ERR_DATA_TRUNC;
                end
            end
            default: begin
                // Bytes after the status are swallowed until end of file.
            end
        endcase

        if (sts_v) begin
            n_phase = PH_DRAIN;
        end

        // End of file returns the parser to the start of a new file.
        if (r_in_eof) begin
            n_phase     = PH_RIFF;
            n_byte_cnt  = '0;
            n_chunk_len = '0;
            n_chunk_tag = '0;
            n_hdr_bad   = 1'b0;
            n_fmt_seen  = 1'b0;
            n_fmt_code  = '0;
            n_chan_cnt  = '0;
            n_decl_rate = '0;
            n_smp_bits  = '0;
            n_low_byte  = '0;
        end
    end

    // Parser state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_byte_cnt  <= '0;
            r_chunk_len <= '0;
            r_chunk_tag <= '0;
            r_hdr_bad   <= 1'b0;
            r_fmt_seen  <= 1'b0;
            r_fmt_code  <= '0;
            r_chan_cnt  <= '0;
            r_decl_rate <= '0;
            r_smp_bits  <= '0;
            r_low_byte  <= '0;
        end else if (adv) begin
            r_phase     <= n_phase;
            r_byte_cnt  <= n_byte_cnt;
            r_chunk_len <= n_chunk_len;
            r_chunk_tag <= n_chunk_tag;
            r_hdr_bad   <= n_hdr_bad;
            r_fmt_seen  <= n_fmt_seen;
            r_fmt_code  <= n_fmt_code;
            r_chan_cnt  <= n_chan_cnt;
            r_decl_rate <= n_decl_rate;
            r_smp_bits  <= n_smp_bits;
            r_low_byte  <= n_low_byte;
        end
    end

    // Result items; a sample goes ahead of a status from the same byte.
    always_comb begin
        res_smp.kind   = KIND_SAMPLE;
        res_smp.sample = {r_in_byte, r_low_byte};
        res_smp.err    = ERR_NONE;
        res_smp.last   = 1'b0;
        res_sts.kind   = (sts_err == ERR_NONE) ? KIND_DONE : KIND_ERROR;
        res_sts.sample = '0;
        res_sts.err    = sts_err;
        res_sts.last   = 1'b1;
        e0             = smp_v ? res_smp : res_sts;
        n_push         = adv ? ({1'b0, smp_v} + {1'b0, sts_v}) : 2'd0;
    end

    assign wp_nx = r_wp + QPTR_W'(1);

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_q[r_wp] <= e0;
        end
        if (n_push == 2'd2) begin
            r_q[wp_nx] <= res_sts;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QPTR_W'(n_push);
            r_rp  <= r_rp + QPTR_W'(pop);
            r_cnt <= r_cnt + QCNT_W'(n_push) - QCNT_W'(pop);
        end
    end

    assign o_kind       = r_q[r_rp].kind;
    assign o_sample     = r_q[r_rp].sample;
    assign o_error_code = r_q[r_rp].err;
    assign o_last       = r_q[r_rp].last;

`ifndef NO_ASSERTIONS
    // The queue never overfills.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // Input is held off only while a byte waits in the input register.
    a_hold_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_vld)
        else $error("input stalled with empty input register");

    // A status result closes its file and a sample never does.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind != KIND_SAMPLE)))
        else $error("last flag does not match result kind");

    // Samples are only produced inside a data chunk.
    a_smp_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && smp_v) |-> (r_phase == PH_DATA))
        else $error("sample outside data chunk");
`endif

endmodule
